@@ hdl/ilm_pkg.sv @@
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared constants and types for the Ising lattice Metropolis block.
// ----------------------------------------------------------------------------
package ilm_pkg;

  localparam int SIDE   = 64;
  localparam int ROW_W  = $clog2(SIDE);
  localparam int ADDR_W = 2 * ROW_W;
  localparam int CELLS  = SIDE * SIDE;
  localparam int PROB_W = 16;
  localparam int DE_W   = 5;
  localparam int E_W    = 15;
  localparam int M_W    = 14;
  localparam int CFG_W  = 1;

  localparam logic signed [E_W-1:0] ENERGY_RESET = E_W'(-2 * CELLS);
  localparam logic signed [M_W-1:0] MAG_RESET    = M_W'(CELLS);
  localparam logic [PROB_W-1:0]     P4_RESET     = PROB_W'(11240);
  localparam logic [PROB_W-1:0]     P8_RESET     = PROB_W'(1928);

  localparam logic [CFG_W-1:0] CFG_P4 = 1'b0;
  localparam logic [CFG_W-1:0] CFG_P8 = 1'b1;

  // read order of the five sites of one item
  localparam logic [2:0] RD_CENTER = 3'd0;
  localparam logic [2:0] RD_DOWN   = 3'd1;
  localparam logic [2:0] RD_UP     = 3'd2;
  localparam logic [2:0] RD_RIGHT  = 3'd3;
  localparam logic [2:0] RD_LEFT   = 3'd4;

  localparam logic MODE_LOAD = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

@@ hdl/ilm_ram.sv @@
// ----------------------------------------------------------------------------
// ilm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ilm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ising_lattice_metropolis_step.sv @@
// ----------------------------------------------------------------------------
// ising_lattice_metropolis_step
// Periodic 2-D Ising lattice with single-site load and Metropolis flip items.
// ----------------------------------------------------------------------------
// After reset the block writes every site of the lattice RAM in turn,
// setting every spin up, and accepts no item meanwhile; configuration
// writes are taken at any time. An item then passes the states READ,
// LAST, EVAL and DONE: in READ the site and its four wrapped neighbours
// are read one per cycle through the single read port of the lattice RAM,
// in LAST the registered read returns the last spin, EVAL decides and
// writes back, and DONE loads the output register once it is free. Then
// IDLE follows, where the next item is accepted, so items never overlap.
// The next item is taken while a result waits in the output register.
module ising_lattice_metropolis_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [ilm_pkg::ROW_W-1:0]     site_row,
  input  logic [ilm_pkg::ROW_W-1:0]     site_col,
  input  logic                          spin_value,
  input  logic [ilm_pkg::PROB_W-1:0]    rand_fraction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          flipped,
  output logic signed [ilm_pkg::DE_W-1:0] delta_energy,
  output logic signed [ilm_pkg::E_W-1:0]  energy,
  output logic signed [ilm_pkg::M_W-1:0]  magnetization,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ilm_pkg::CFG_W-1:0]     cfg_index,
  input  logic [ilm_pkg::PROB_W-1:0]    cfg_data
);
  import ilm_pkg::*;

  state_t state, state_next;

  logic [ADDR_W-1:0]      clr_addr;
  logic [2:0]             cnt;
  logic                   cap;
  logic [2:0]             cap_idx;
  logic                   item_mode;
  logic [ROW_W-1:0]       item_row;
  logic [ROW_W-1:0]       item_col;
  logic                   item_want;
  logic [PROB_W-1:0]      item_rnd;
  logic                   spin_c;
  logic [2:0]             ups;
  logic signed [DE_W-1:0] de;
  logic                   change;
  logic signed [E_W-1:0]  energy_tot;
  logic signed [M_W-1:0]  mag_tot;
  logic [PROB_W-1:0]      p4;
  logic [PROB_W-1:0]      p8;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic                   ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic                   ram_rdata;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       rd_col;

  logic signed [DE_W-1:0] base;
  logic signed [DE_W-1:0] de_w;
  logic                   change_w;

  ilm_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_lattice (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // dE = s * (4*ups - 8)
  always_comb begin
    base = $signed({ups, 2'b00}) - DE_W'(8);
    de_w = spin_c ? base : -base;
    if (item_mode == MODE_LOAD) begin
      change_w = (spin_c != item_want);
    end else if (de_w <= 0) begin
      change_w = 1'b1;
    end else if (de_w == DE_W'(4)) begin
      change_w = item_rnd < p4;
    end else begin
      change_w = item_rnd < p8;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ:  if (cnt == RD_LEFT) state_next = ST_LAST;
      ST_LAST:  state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_row = item_row;
    rd_col = item_col;
    case (cnt)
      RD_CENTER: ;
      RD_DOWN:   rd_row = item_row + 1'b1;
      RD_UP:     rd_row = item_row - 1'b1;
      RD_RIGHT:  rd_col = item_col + 1'b1;
      RD_LEFT:   rd_col = item_col - 1'b1;
      default:   ;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    ram_raddr = {rd_row, rd_col};
    ram_we    = 1'b0;
    ram_waddr = {item_row, item_col};
    ram_wdata = ~spin_c;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 1'b1;
      end
      ST_EVAL:  ram_we = change_w;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cnt       <= '0;
      cap       <= 1'b0;
      energy_tot <= ENERGY_RESET;
      mag_tot   <= MAG_RESET;
      p4        <= P4_RESET;
      p8        <= P8_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cap   <= (state == ST_READ);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_P4:  p4 <= cfg_data;
          CFG_P8:  p8 <= cfg_data;
          default: ;
        endcase
      end

      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      if (in_valid && in_ready) begin
        cnt <= RD_CENTER;
      end else if (state == ST_READ) begin
        cnt <= cnt + 1'b1;
      end

      if (state == ST_EVAL && change_w) begin
        energy_tot <= energy_tot + E_W'(de_w);
        mag_tot    <= spin_c ? mag_tot - M_W'(2) : mag_tot + M_W'(2);
      end

      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= cnt;
    if (in_valid && in_ready) begin
      item_mode <= mode;
      item_row  <= site_row;
      item_col  <= site_col;
      item_want <= spin_value;
      item_rnd  <= rand_fraction;
      ups       <= '0;
    end else if (cap) begin
      if (cap_idx == RD_CENTER) begin
        spin_c <= ram_rdata;
      end else begin
        ups <= ups + {2'b00, ram_rdata};
      end
    end
    if (state == ST_EVAL) begin
      change <= change_w;
      de     <= change_w ? de_w : '0;
    end
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      flipped       <= change;
      delta_energy  <= de;
      energy        <= energy_tot;
      magnetization <= mag_tot;
    end
  end

  // every spin flip moves M by 2 and E by a multiple of 4
  a_mag_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnetization[0] == 1'b0)
    else $error("odd magnetization");

  a_energy_mult4: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> energy[1:0] == 2'b00)
    else $error("energy not a multiple of four");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !flipped |-> delta_energy == '0)
    else $error("energy change without flip");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

endmodule

@@ sim/ising_lattice_metropolis_step_tb.sv @@
// ----------------------------------------------------------------------------
// ising_lattice_metropolis_step_tb
// Self-checking bench for the periodic Ising lattice Metropolis block.
// ----------------------------------------------------------------------------
// A shadow lattice with its own energy, magnetization and acceptance
// thresholds predicts every result. Directed loads and flips hit the lattice
// corners, every energy change and both threshold boundaries. Random traffic,
// clustered in a moving window so that neighbours interact, then runs under
// several threshold settings, back to back and under a long output stall.
// ----------------------------------------------------------------------------
module ising_lattice_metropolis_step_tb;
  import ilm_pkg::*;

  localparam logic MODE_FLIP   = ~MODE_LOAD;
  localparam int   STALL_LIMIT = 20000;
  localparam int   SETTLE_CYC  = 12;
  localparam int   PHASE_ITEMS = 240;

  typedef struct {
    logic              m;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic              sv;
    logic [PROB_W-1:0] rnd;
  } site_req_t;

  typedef struct {
    logic                     flipped;
    logic signed [DE_W-1:0]   de;
    logic signed [E_W-1:0]    en;
    logic signed [M_W-1:0]    mag;
  } outcome_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      mode;
  logic [ROW_W-1:0]          site_row;
  logic [ROW_W-1:0]          site_col;
  logic                      spin_value;
  logic [PROB_W-1:0]         rand_fraction;
  logic                      out_valid;
  logic                      out_ready;
  logic                      flipped;
  logic signed [DE_W-1:0]    delta_energy;
  logic signed [E_W-1:0]     energy;
  logic signed [M_W-1:0]     magnetization;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_index;
  logic [PROB_W-1:0]         cfg_data;

  // shadow state
  logic              spin_grid [CELLS];
  int                lat_energy;
  int                lat_mag;
  logic [PROB_W-1:0] thr_four;
  logic [PROB_W-1:0] thr_eight;

  outcome_t expected_updates [$];

  int n_errors;
  int n_results;
  int n_loads;
  int n_attempts;
  int n_uphill;
  int n_settings;
  int idle_cycles;
  int hold_req;
  bit no_gaps;
  logic [ROW_W-1:0] win_row;
  logic [ROW_W-1:0] win_col;

  ising_lattice_metropolis_step dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .site_row      (site_row),
    .site_col      (site_col),
    .spin_value    (spin_value),
    .rand_fraction (rand_fraction),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .flipped       (flipped),
    .delta_energy  (delta_energy),
    .energy        (energy),
    .magnetization (magnetization),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int spin_of(int r, int c);
    return spin_grid[((r + SIDE) % SIDE) * SIDE + ((c + SIDE) % SIDE)] ? 1 : -1;
  endfunction

  function automatic outcome_t predict_site_update(site_req_t q);
    int       r;
    int       c;
    int       idx;
    int       s;
    int       de;
    logic     change;
    outcome_t o;
    r   = int'(q.row);
    c   = int'(q.col);
    idx = r * SIDE + c;
    s   = spin_of(r, c);
    de  = 2 * s * (spin_of(r + 1, c) + spin_of(r - 1, c)
                 + spin_of(r, c + 1) + spin_of(r, c - 1));
    if (q.m == MODE_LOAD) begin
      n_loads++;
      change = (spin_grid[idx] != q.sv);
    end else begin
      n_attempts++;
      if (de <= 0) begin
        change = 1'b1;
      end else if (de == 4) begin
        change = (q.rnd < thr_four);
      end else begin
        change = (q.rnd < thr_eight);
      end
      if (change && de > 0) n_uphill++;
    end
    if (change) begin
      spin_grid[idx] = ~spin_grid[idx];
      lat_energy += de;
      lat_mag    -= 2 * s;
    end else begin
      de = 0;
    end
    o.flipped = change;
    o.de      = DE_W'(de);
    o.en      = E_W'(lat_energy);
    o.mag     = M_W'(lat_mag);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR result %0d: %s", n_results, msg);
    n_errors++;
  endtask

  task automatic send_request(site_req_t q);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= q.m;
    site_row      <= q.row;
    site_col      <= q.col;
    spin_value    <= q.sv;
    rand_fraction <= q.rnd;
    do @(posedge clk); while (!in_ready);
    expected_updates.push_back(predict_site_update(q));
  endtask

  task automatic send_fields(logic m, int r, int c, logic sv, int rnd);
    site_req_t q;
    q.m   = m;
    q.row = ROW_W'(r);
    q.col = ROW_W'(c);
    q.sv  = sv;
    q.rnd = PROB_W'(rnd);
    send_request(q);
  endtask

  task automatic write_threshold(logic [CFG_W-1:0] idx, logic [PROB_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_P4) thr_four = val;
    else thr_eight = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_updates.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic site_req_t random_request();
    site_req_t q;
    int k;
    q.m  = ($urandom_range(0, 99) < 35) ? MODE_LOAD : MODE_FLIP;
    q.sv = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 65) begin
      q.row = win_row + ROW_W'($urandom_range(0, 5));
      q.col = win_col + ROW_W'($urandom_range(0, 5));
    end else begin
      q.row = ROW_W'($urandom);
      q.col = ROW_W'($urandom);
    end
    k = $urandom_range(0, 99);
    if (k < 15)      q.rnd = PROB_W'(int'(thr_four) + $urandom_range(0, 2) - 1);
    else if (k < 30) q.rnd = PROB_W'(int'(thr_eight) + $urandom_range(0, 2) - 1);
    else if (k < 36) q.rnd = '0;
    else if (k < 42) q.rnd = '1;
    else             q.rnd = PROB_W'($urandom);
    return q;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        win_row = ROW_W'($urandom);
        win_col = ROW_W'($urandom);
      end
      send_request(random_request());
    end
  endtask

  // corners, every energy change, threshold boundaries, ignored fields
  task automatic test_directed_cases();
    send_fields(MODE_FLIP, 0, 0, 1'b0, 16'hFFFF);
    send_fields(MODE_FLIP, 63, 63, 1'b1, 0);
    send_fields(MODE_LOAD, 63, 63, 1'b0, 16'hFFFF);
    send_fields(MODE_LOAD, 63, 0, 1'b0, 0);
    send_fields(MODE_FLIP, 0, 63, 1'b0, int'(thr_four) - 1);
    send_fields(MODE_FLIP, 0, 62, 1'b1, int'(thr_four));
    send_fields(MODE_FLIP, 63, 62, 1'b0, 0);
    send_fields(MODE_FLIP, 0, 0, 1'b1, 16'hFFFF);
    send_fields(MODE_LOAD, 10, 10, 1'b0, 1234);
    send_fields(MODE_FLIP, 10, 10, 1'b1, 16'hFFFF);
    send_fields(MODE_LOAD, 31, 30, 1'b0, 16'hFFFF);
    send_fields(MODE_LOAD, 29, 30, 1'b0, 0);
    send_fields(MODE_LOAD, 30, 29, 1'b0, 16'h5555);
    send_fields(MODE_FLIP, 30, 30, 1'b0, 16'hFFFF);
    send_fields(MODE_FLIP, 30, 30, 1'b1, 16'hFFFF);
    send_fields(MODE_FLIP, 30, 30, 1'b1, 0);
    send_fields(MODE_LOAD, 63, 63, 1'b1, 16'hAAAA);
    send_fields(MODE_LOAD, 0, 0, 1'b1, 0);
    send_fields(MODE_FLIP, 5, 5, 1'b1, int'(thr_eight) - 1);
    send_fields(MODE_FLIP, 40, 40, 1'b0, int'(thr_eight));
    send_fields(MODE_LOAD, 63, 31, 1'b1, 16'hFFFF);
    send_fields(MODE_LOAD, 0, 31, 1'b0, 16'hFFFF);
    wait_idle();
  endtask

  task automatic test_threshold_settings();
    logic [PROB_W-1:0] four_set  [5];
    logic [PROB_W-1:0] eight_set [5];
    four_set  = '{P4_RESET, 16'h0000, 16'hFFFF, PROB_W'($urandom), 16'hFFFF};
    eight_set = '{P8_RESET, 16'h0000, 16'hFFFF, PROB_W'($urandom), 16'h0000};
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        write_threshold(CFG_P4, four_set[p]);
        write_threshold(CFG_P8, eight_set[p]);
      end
      n_settings++;
      send_random(PHASE_ITEMS);
      wait_idle();
    end
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    send_random(120);
    wait_idle();
    no_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_req = 300;
    send_random(100);
    wait_idle();
  endtask

  // result receiver: random stalls, plus a long hold on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    forever begin
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && hold_req == 0);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_updates.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_updates.pop_front();
        if (flipped !== want.flipped)
          report_mismatch($sformatf("flipped got %0b exp %0b", flipped, want.flipped));
        if (delta_energy !== want.de)
          report_mismatch($sformatf("delta_energy got %0d exp %0d", delta_energy, want.de));
        if (energy !== want.en)
          report_mismatch($sformatf("energy got %0d exp %0d", energy, want.en));
        if (magnetization !== want.mag)
          report_mismatch($sformatf("magnetization got %0d exp %0d",
                                    magnetization, want.mag));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("ising_lattice_metropolis_step_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    mode          <= MODE_LOAD;
    site_row      <= '0;
    site_col      <= '0;
    spin_value    <= 1'b0;
    rand_fraction <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_P4;
    cfg_data      <= '0;
    idle_cycles   = 0;
    hold_req      = 0;
    no_gaps       = 1'b0;
    n_errors      = 0;
    n_results     = 0;
    n_loads       = 0;
    n_attempts    = 0;
    n_uphill      = 0;
    n_settings    = 0;
    foreach (spin_grid[i]) spin_grid[i] = 1'b1;
    lat_energy = int'(ENERGY_RESET);
    lat_mag    = int'(MAG_RESET);
    thr_four   = P4_RESET;
    thr_eight  = P8_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_threshold_settings();
    test_back_to_back();
    test_output_backpressure();

    if (expected_updates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_updates.size()));
    $display("covered %0d loads and %0d flip attempts (%0d uphill accepted) over %0d settings",
             n_loads, n_attempts, n_uphill, n_settings);
    $display("checked %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("ising_lattice_metropolis_step_tb passed");
    end else begin
      $display("ising_lattice_metropolis_step_tb failed");
    end
    $finish;
  end

endmodule

@@ ising_lattice_metropolis_step.f @@
hdl/ilm_pkg.sv
hdl/ilm_ram.sv
hdl/ising_lattice_metropolis_step.sv
sim/ising_lattice_metropolis_step_tb.sv
